/* hw/rtl/tpfm_pkg.sv */
// Shared types, codes and field layouts of the tank pressure fault monitor.
package tpfm_pkg;

  localparam int unsigned PressW   = 16;
  localparam int unsigned NumPress = 4;
  localparam int unsigned NumOver  = 3;
  localparam int unsigned NumRemote = 3;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic signed [PressW-1:0] DisconnectLevelRst = 16'sd0;
  localparam logic signed [PressW-1:0] CriticalLevelRst   = 16'sd6000;
  localparam logic signed [PressW-1:0] HalfAbortLevelRst  = 16'sd5000;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] RegDisconnectLevel = 2'd0;
  localparam logic [1:0] RegCriticalLevel   = 2'd1;
  localparam logic [1:0] RegHalfAbortLevel  = 2'd2;

  // Mode codes
  localparam logic [1:0] ModeIdle       = 2'd0;
  localparam logic [1:0] ModeControlled = 2'd1;
  localparam logic [1:0] ModeOther      = 2'd2;

  typedef enum logic [1:0] {
    CmdNone      = 2'd0,
    CmdShutdown  = 2'd1,
    CmdHalfAbort = 2'd2
  } command_e;

  typedef struct packed {
    logic [NumRemote-1:0] nores;
    logic [NumOver-1:0]   ha;
    logic [NumOver-1:0]   crit;
    logic [NumPress-1:0]  disc;
  } flags_t;

  typedef struct packed {
    logic [1:0]  noresponse_count;
    logic [2:0]  disconnect_count;
    command_e    command;
    logic        half_abort_latched;
    logic        critical_latched;
    logic [16:0] fault_flags;
  } result_t;

endpackage

/* hw/rtl/tpfm_lane.sv */
// One threshold lane: compares a pressure with a level and updates its flag.
module tpfm_lane (
  input  logic signed [tpfm_pkg::PressW-1:0] value_i,
  input  logic signed [tpfm_pkg::PressW-1:0] level_i,
  input  logic                               above_i,
  input  logic                               flag_i,
  output logic                               flag_o
);

  logic over;
  logic under;
  logic bad;
  logic good;

  assign over  = value_i > level_i;
  assign under = value_i < level_i;
  assign bad   = above_i ? over : under;
  assign good  = above_i ? under : over;

  always_comb begin
    if (bad) begin
      flag_o = 1'b1;
    end else if (good) begin
      flag_o = 1'b0;
    end else begin
      flag_o = flag_i;
    end
  end

endmodule

/* hw/rtl/tpfm_merge.sv */
// Merge stage: summary flags, counts, sticky latches and command.
module tpfm_merge (
  input  tpfm_pkg::flags_t  flags_i,
  input  logic              crit_latch_i,
  input  logic              ha_latch_i,
  input  logic [1:0]        mode_i,
  output tpfm_pkg::result_t result_o
);

  logic [3:0] summary;
  logic [2:0] disc_cnt;
  logic [1:0] nores_cnt;
  logic       crit_latch;
  logic       ha_latch;

  assign summary[0] = flags_i.disc[0] | flags_i.crit[0] | flags_i.ha[0];
  assign summary[1] = flags_i.disc[1] | flags_i.nores[0];
  assign summary[2] = flags_i.disc[2] | flags_i.crit[1] | flags_i.ha[1] | flags_i.nores[1];
  assign summary[3] = flags_i.disc[3] | flags_i.crit[2] | flags_i.ha[2] | flags_i.nores[2];

  assign disc_cnt = {2'b0, flags_i.disc[0]} + {2'b0, flags_i.disc[1]}
                  + {2'b0, flags_i.disc[2]} + {2'b0, flags_i.disc[3]};
  assign nores_cnt = {1'b0, flags_i.nores[0]} + {1'b0, flags_i.nores[1]}
                   + {1'b0, flags_i.nores[2]};

  assign crit_latch = crit_latch_i | (|flags_i.crit);
  assign ha_latch   = ha_latch_i | (|flags_i.ha) | (disc_cnt > 3'd2) | (nores_cnt == 2'd3);

  always_comb begin
    result_o.fault_flags        = {summary, flags_i.nores, flags_i.ha, flags_i.crit,
                                   flags_i.disc};
    result_o.critical_latched   = crit_latch;
    result_o.half_abort_latched = ha_latch;
    result_o.disconnect_count   = disc_cnt;
    result_o.noresponse_count   = nores_cnt;
    if (crit_latch) begin
      result_o.command = (mode_i != tpfm_pkg::ModeIdle) ? tpfm_pkg::CmdShutdown
                                                          : tpfm_pkg::CmdNone;
    end else if (ha_latch && mode_i == tpfm_pkg::ModeControlled) begin
      result_o.command = tpfm_pkg::CmdHalfAbort;
    end else begin
      result_o.command = tpfm_pkg::CmdNone;
    end
  end

endmodule

/* hw/rtl/tank_pressure_fault_monitor.sv */
// Tank pressure fault monitor top level: APB registers, lanes, merge, output buffer.
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    s_axis_tdata[71:0]
//  m_axis   out  m_axis_tvalid/tready    m_axis_tdata[31:0]
//  apb      in   psel/penable/pready     paddr[3:0], pwdata/prdata[31:0]
//
// One tick per cycle while the output buffer has room; each result is registered into the buffer.
// Lanes and merge are a single combinational level in front of the state flops.
// A two-entry output buffer keeps input ready while one result waits downstream.
// Reset clears all flags, latches and the buffer; levels return to defaults.
module tank_pressure_fault_monitor (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] local_fuel_p, [31:16] remote_n2_p, [47:32] remote_fuel_p,
  // [63:48] remote_ox_p, [64] polling_active, [65] n2_responded,
  // [66] fuel_responded, [67] ox_responded, [69:68] mode, [71:70] zero
  input  logic [tpfm_pkg::InDataW-1:0]          s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [16:0] fault_flags, [17] critical_latched, [18] half_abort_latched,
  // [20:19] command, [23:21] disconnect_count, [25:24] noresponse_count,
  // [31:26] zero
  output logic [tpfm_pkg::OutDataW-1:0]         m_axis_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tpfm_pkg::CfgAddrW-1:0]         paddr,
  input  logic [tpfm_pkg::CfgDataW-1:0]         pwdata,
  output logic [tpfm_pkg::CfgDataW-1:0]         prdata,
  output logic                                  pready
);

  // Configuration registers
  logic signed [tpfm_pkg::PressW-1:0] disc_level_q;
  logic signed [tpfm_pkg::PressW-1:0] crit_level_q;
  logic signed [tpfm_pkg::PressW-1:0] ha_level_q;
  logic                               cfg_we;
  logic [1:0]                         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_level_q <= tpfm_pkg::DisconnectLevelRst;
      crit_level_q <= tpfm_pkg::CriticalLevelRst;
      ha_level_q   <= tpfm_pkg::HalfAbortLevelRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tpfm_pkg::RegDisconnectLevel: disc_level_q <= pwdata[tpfm_pkg::PressW-1:0];
        tpfm_pkg::RegCriticalLevel:   crit_level_q <= pwdata[tpfm_pkg::PressW-1:0];
        tpfm_pkg::RegHalfAbortLevel:  ha_level_q   <= pwdata[tpfm_pkg::PressW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tpfm_pkg::RegDisconnectLevel: prdata = {16'b0, disc_level_q};
      tpfm_pkg::RegCriticalLevel:   prdata = {16'b0, crit_level_q};
      tpfm_pkg::RegHalfAbortLevel:  prdata = {16'b0, ha_level_q};
      default:                      prdata = '0;
    endcase
  end

  // Input unpacking
  logic signed [tpfm_pkg::PressW-1:0] press [tpfm_pkg::NumPress];
  logic signed [tpfm_pkg::PressW-1:0] over_press [tpfm_pkg::NumOver];
  logic                               polling;
  logic [tpfm_pkg::NumRemote-1:0]     responded;
  logic [1:0]                         mode;
  logic                               in_xfer;

  assign press[0]      = s_axis_tdata[15:0];
  assign press[1]      = s_axis_tdata[31:16];
  assign press[2]      = s_axis_tdata[47:32];
  assign press[3]      = s_axis_tdata[63:48];
  assign over_press[0] = press[0];
  assign over_press[1] = press[2];
  assign over_press[2] = press[3];
  assign polling       = s_axis_tdata[64];
  assign responded     = s_axis_tdata[67:65];
  assign mode          = s_axis_tdata[69:68];
  assign in_xfer       = s_axis_tvalid & s_axis_tready;

  // Flag state
  tpfm_pkg::flags_t flags_q;
  tpfm_pkg::flags_t flags_d;
  logic             crit_latch_q;
  logic             ha_latch_q;
  tpfm_pkg::result_t res;

  for (genvar g = 0; g < tpfm_pkg::NumPress; g++) begin : g_disc
    tpfm_lane u_disc_lane (
      .value_i (press[g]),
      .level_i (disc_level_q),
      .above_i (1'b0),
      .flag_i  (flags_q.disc[g]),
      .flag_o  (flags_d.disc[g])
    );
  end

  for (genvar g = 0; g < tpfm_pkg::NumOver; g++) begin : g_over
    tpfm_lane u_crit_lane (
      .value_i (over_press[g]),
      .level_i (crit_level_q),
      .above_i (1'b1),
      .flag_i  (flags_q.crit[g]),
      .flag_o  (flags_d.crit[g])
    );
    tpfm_lane u_ha_lane (
      .value_i (over_press[g]),
      .level_i (ha_level_q),
      .above_i (1'b1),
      .flag_i  (flags_q.ha[g]),
      .flag_o  (flags_d.ha[g])
    );
  end

  assign flags_d.nores = polling ? ~responded : flags_q.nores;

  tpfm_merge u_merge (
    .flags_i      (flags_d),
    .crit_latch_i (crit_latch_q),
    .ha_latch_i   (ha_latch_q),
    .mode_i       (mode),
    .result_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q      <= '0;
      crit_latch_q <= 1'b0;
      ha_latch_q   <= 1'b0;
    end else if (in_xfer) begin
      flags_q      <= flags_d;
      crit_latch_q <= res.critical_latched;
      ha_latch_q   <= res.half_abort_latched;
    end
  end

  // Two-entry output buffer
  tpfm_pkg::result_t head_q;
  tpfm_pkg::result_t tail_q;
  logic [1:0]        count_q;
  logic              out_xfer;

  assign s_axis_tready = (count_q != 2'd2);
  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tdata  = {6'b0, head_q};
  assign out_xfer      = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (in_xfer && !out_xfer) begin
      count_q <= count_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && out_xfer) begin
      if (count_q == 2'd1) begin
        head_q <= res;
      end else begin
        head_q <= tail_q;
        tail_q <= res;
      end
    end else if (out_xfer) begin
      head_q <= tail_q;
    end else if (in_xfer) begin
      if (count_q == 2'd0) begin
        head_q <= res;
      end else begin
        tail_q <= res;
      end
    end
  end

  // Checks
  a_crit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crit_latch_q |=> crit_latch_q)
    else $error("critical latch cleared");

  a_ha_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ha_latch_q |=> ha_latch_q)
    else $error("half-abort latch cleared");

  a_cmd_priority: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && head_q.critical_latched |-> head_q.command != tpfm_pkg::CmdHalfAbort)
    else $error("half-abort command while critical latched");

  a_ha_flag_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (head_q.fault_flags[9:7] != 3'b0) |-> head_q.half_abort_latched)
    else $error("half-abort flag without latch");

  a_buffer_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 && !out_xfer |=> count_q == 2'd2 && $stable(head_q))
    else $error("full output buffer lost or changed an entry");

endmodule
